@@ design/dlps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared types, constants and coefficient tables for the delay line pitch
// shifter.
// ----------------------------------------------------------------------------
package dlps_pkg;

  localparam int unsigned DELAY_DEPTH_DEF = 4096;
  localparam int unsigned SAMPLE_W        = 24;
  localparam int unsigned FRAC_W          = 16;
  localparam int unsigned COEF_W          = 17;
  localparam int unsigned RATIO_W         = 18;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 17;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned WIN_MIN_BASE    = 512;
  localparam int unsigned WIN_SPAN        = 3584;
  localparam int unsigned WIN_FLOOR       = 64;

  localparam logic [COEF_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [COEF_W-1:0] MIX_ONE  = 17'd32768;
  localparam logic [15:0]       MIX_MAX  = 16'd32768;
  localparam logic [16:0]       QUAL_MAX = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEMITONES = 2'd0,
    CFG_CENTS     = 2'd1,
    CFG_MIX       = 2'd2,
    CFG_QUALITY   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_NORM,
    BK_WRITE,
    BK_ISSUE,
    BK_MAC,
    BK_FIN,
    BK_WRAP
  } bk_state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_result;
    logic signed [SAMPLE_W-1:0] right_result;
  } out_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    in_t  item;
  } head_t;

  typedef struct packed {
    logic init_done;
    logic busy;
  } bk_status_t;

  // 2^(n/12), Q16
  function automatic logic [COEF_W-1:0] semi_coef(input logic [3:0] idx);
    logic [COEF_W-1:0] c;
    case (idx)
      4'd0:    c = 17'd65536;
      4'd1:    c = 17'd69433;
      4'd2:    c = 17'd73562;
      4'd3:    c = 17'd77936;
      4'd4:    c = 17'd82570;
      4'd5:    c = 17'd87480;
      4'd6:    c = 17'd92682;
      4'd7:    c = 17'd98193;
      4'd8:    c = 17'd104032;
      4'd9:    c = 17'd110218;
      4'd10:   c = 17'd116772;
      4'd11:   c = 17'd123715;
      default: c = 17'd65536;
    endcase
    return c;
  endfunction

  // 2^(10n/1200), Q16
  function automatic logic [COEF_W-1:0] tens_coef(input logic [3:0] idx);
    logic [COEF_W-1:0] c;
    case (idx)
      4'd0:    c = 17'd65536;
      4'd1:    c = 17'd65916;
      4'd2:    c = 17'd66297;
      4'd3:    c = 17'd66682;
      4'd4:    c = 17'd67068;
      4'd5:    c = 17'd67456;
      4'd6:    c = 17'd67847;
      4'd7:    c = 17'd68240;
      4'd8:    c = 17'd68635;
      4'd9:    c = 17'd69033;
      default: c = 17'd65536;
    endcase
    return c;
  endfunction

  // 2^(n/1200), Q16
  function automatic logic [COEF_W-1:0] unit_coef(input logic [3:0] idx);
    logic [COEF_W-1:0] c;
    case (idx)
      4'd0:    c = 17'd65536;
      4'd1:    c = 17'd65574;
      4'd2:    c = 17'd65612;
      4'd3:    c = 17'd65650;
      4'd4:    c = 17'd65688;
      4'd5:    c = 17'd65726;
      4'd6:    c = 17'd65764;
      4'd7:    c = 17'd65802;
      4'd8:    c = 17'd65840;
      4'd9:    c = 17'd65878;
      default: c = 17'd65536;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ design/dlps_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dlps_front
// Input side: takes sample pairs and holds them in a short queue for the
// back end.
// ----------------------------------------------------------------------------
module dlps_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire dlps_pkg::in_t in_data_i,
  output dlps_pkg::head_t    head_o,
  input  wire logic          pop_i
);

  localparam int unsigned PTR_W = $clog2(dlps_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(dlps_pkg::QUEUE_DEPTH + 1);

  dlps_pkg::in_t    buf_q [dlps_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_q, rp_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push;

  assign in_ready_o = en_i && (cnt_q != CNT_W'(dlps_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = buf_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == PTR_W'(dlps_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PTR_W'(dlps_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= in_data_i;
    end
  end

endmodule
`default_nettype wire

@@ design/dlps_ratio.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dlps_ratio
// Pitch ratio, Q2.16, from the semitone and cent registers. Four register
// stages; the ratio follows a write to those registers through them.
// ----------------------------------------------------------------------------
module dlps_ratio (
  input  wire logic                         clk_i,
  input  wire logic [4:0]                   semis_i,
  input  wire logic [7:0]                   cents_i,
  output logic [dlps_pkg::RATIO_W-1:0]      ratio_o
);

  localparam int unsigned CW = dlps_pkg::COEF_W;

  logic signed [5:0] s_cl;
  logic signed [7:0] c_cl;
  logic [5:0]        k_base, k_adj;
  logic [6:0]        cu;
  logic [1:0]        oct;
  logic [3:0]        semi_idx, tens_idx, unit_idx;
  logic [14:0]       tmul;

  logic [CW-1:0]     semi_q, tens_q, unit_q, unit2_q;
  logic [1:0]        oct1_q, oct2_q, oct3_q;
  logic [17:0]       v1_q, v2_q;
  logic [33:0]       m1;
  logic [34:0]       m2;
  logic [20:0]       scaled;
  logic [dlps_pkg::RATIO_W-1:0] ratio_q;

  // clamp, then split u = 100*s + c + 2400 into octave, semitone, tens, units
  always_comb begin
    if ($signed(semis_i) < -5'sd12) begin
      s_cl = -6'sd12;
    end else if ($signed(semis_i) > 5'sd12) begin
      s_cl = 6'sd12;
    end else begin
      s_cl = 6'($signed(semis_i));
    end
    if ($signed(cents_i) < -8'sd100) begin
      c_cl = -8'sd100;
    end else if ($signed(cents_i) > 8'sd100) begin
      c_cl = 8'sd100;
    end else begin
      c_cl = $signed(cents_i);
    end

    k_base = 6'(7'(s_cl) + 7'sd24);
    if (c_cl == -8'sd100) begin
      k_adj = k_base - 6'd1;
      cu    = '0;
    end else if (c_cl < 8'sd0) begin
      k_adj = k_base - 6'd1;
      cu    = 7'(c_cl + 8'sd100);
    end else if (c_cl == 8'sd100) begin
      k_adj = k_base + 6'd1;
      cu    = '0;
    end else begin
      k_adj = k_base;
      cu    = 7'(c_cl);
    end

    if (k_adj < 6'd12) begin
      oct = 2'd0;
    end else if (k_adj < 6'd24) begin
      oct = 2'd1;
    end else if (k_adj < 6'd36) begin
      oct = 2'd2;
    end else begin
      oct = 2'd3;
    end
    semi_idx = 4'(k_adj - 6'd12 * 6'(oct));
    // cu/10 by reciprocal, exact below 100
    tmul     = 15'(cu) * 15'd205;
    tens_idx = tmul[14:11];
    unit_idx = 4'(cu - 7'(tens_idx) * 7'd10);
  end

  assign m1     = 34'(semi_q) * 34'(tens_q);
  assign m2     = 35'(v1_q) * 35'(unit2_q);
  assign scaled = (21'(v2_q) << oct3_q) + 21'd2;

  always_ff @(posedge clk_i) begin
    semi_q  <= dlps_pkg::semi_coef(semi_idx);
    tens_q  <= dlps_pkg::tens_coef(tens_idx);
    unit_q  <= dlps_pkg::unit_coef(unit_idx);
    oct1_q  <= oct;
    v1_q    <= 18'((m1 + 34'd32768) >> 16);
    unit2_q <= unit_q;
    oct2_q  <= oct1_q;
    v2_q    <= 18'((m2 + 35'd32768) >> 16);
    oct3_q  <= oct2_q;
    ratio_q <= dlps_pkg::RATIO_W'(scaled >> 2);
  end

  assign ratio_o = ratio_q;

endmodule
`default_nettype wire

@@ design/dlps_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dlps_div
// Crossfade weight floor(2*pos/W), folded about 1.0. Restoring divider,
// three quotient bits a cycle.
// ----------------------------------------------------------------------------
module dlps_div #(
  parameter int unsigned DELAY_DEPTH = dlps_pkg::DELAY_DEPTH_DEF
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       start_i,
  input  wire logic [$clog2(DELAY_DEPTH)+dlps_pkg::FRAC_W-1:0] pos_i,
  input  wire logic [$clog2(DELAY_DEPTH+1)-1:0]           win_i,
  output logic                                            done_o,
  output logic [dlps_pkg::COEF_W-1:0]                     cf_o
);

  localparam int unsigned WW        = $clog2(DELAY_DEPTH + 1);
  localparam int unsigned QW        = 18;
  localparam int unsigned PER_CYC   = 3;
  localparam int unsigned STEPS     = QW / PER_CYC;
  localparam int unsigned SW        = $clog2(STEPS);

  logic [WW-1:0] rem_q, rem_d;
  logic [QW-1:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [SW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [WW:0]   trial;
  logic [QW-1:0] q_fold;

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    quo_d = quo_q;
    trial = '0;
    for (int i = 0; i < int'(PER_CYC); i++) begin
      trial = {rem_d, dvd_d[QW-1]};
      dvd_d = {dvd_d[QW-2:0], 1'b0};
      if (trial >= {1'b0, win_i}) begin
        trial = trial - {1'b0, win_i};
        quo_d = {quo_d[QW-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[QW-2:0], 1'b0};
      end
      rem_d = trial[WW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == SW'(STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // dividend is 2*pos; its top part (pos >> 17) is already below W
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= WW'(pos_i >> (QW - 1));
      dvd_q <= {pos_i[QW-2:0], 1'b0};
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
      quo_q <= quo_d;
    end
  end

  assign q_fold = (quo_q > QW'(dlps_pkg::ONE_Q16))
                ? (QW'(2) * QW'(dlps_pkg::ONE_Q16) - quo_q) : quo_q;
  assign cf_o   = q_fold[dlps_pkg::COEF_W-1:0];
  assign done_o = done_q;

endmodule
`default_nettype wire

@@ design/dlps_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dlps_back
// Back end: delay store, position bookkeeping, two-lane multiply-accumulate
// sequencer and the output register.
// ----------------------------------------------------------------------------
module dlps_back #(
  parameter int unsigned DELAY_DEPTH = dlps_pkg::DELAY_DEPTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire dlps_pkg::head_t                    head_i,
  output logic                                    pop_o,
  input  wire logic [$clog2(DELAY_DEPTH+1)-1:0]   win_i,
  input  wire logic [dlps_pkg::RATIO_W-1:0]       ratio_i,
  input  wire logic [15:0]                        mix_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output dlps_pkg::out_t                          out_data_o,
  output dlps_pkg::bk_status_t                    status_o
);

  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned WW = $clog2(DELAY_DEPTH + 1);
  localparam int unsigned FW = dlps_pkg::FRAC_W;
  localparam int unsigned PW = AW + FW;
  localparam int unsigned SW = dlps_pkg::SAMPLE_W;
  localparam int unsigned CW = dlps_pkg::COEF_W;
  localparam int unsigned MW = SW + CW + 1;
  localparam int unsigned DW = 2 * SW;
  localparam logic [2:0]  XF_STEP = 3'd4;
  localparam logic [2:0]  LAST_STEP = 3'd7;

  dlps_pkg::bk_state_e state_q, state_d;

  logic [DW-1:0]  store_mem [DELAY_DEPTH];
  logic [DW-1:0]  rdata_q;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [DW-1:0]  mem_wdata;

  logic [AW-1:0]  clr_q;
  logic [PW-1:0]  pos_q;
  logic [WW-1:0]  widx_q;
  logic [AW-1:0]  p1i_q, p2i_q;
  logic [FW-1:0]  f1_q, f2_q;
  logic [2:0]     step_q;

  logic signed [MW-1:0] prod_l_q, prod_r_q, acc_l_q, acc_r_q;
  logic signed [SW-1:0] t1_l_q, t1_r_q, t2_l_q, t2_r_q, wet_l_q, wet_r_q;
  logic                 out_valid_q;
  dlps_pkg::out_t       out_q;

  logic [AW-1:0]  pos_int;
  logic [PW:0]    wq, p2_sum, p2_wrap, pos_sum, pos_next;
  logic           div_start, div_done;
  logic [CW-1:0]  cf;
  logic           mac_go, out_free;
  logic signed [SW-1:0] x_l, x_r;
  logic [CW-1:0]  y_c;
  logic signed [MW:0]   sum_l, sum_r;
  logic signed [MW:0]   r16_l, r16_r, r15_l, r15_r;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i,
                                             input logic [WW-1:0] w);
    logic [WW-1:0] n;
    n = WW'(i) + 1'b1;
    return (n == w) ? '0 : n[AW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sat24(input logic signed [MW:0] v);
    logic signed [SW-1:0] r;
    if (v > (MW+1)'(signed'(24'sh7FFFFF))) begin
      r = 24'sh7FFFFF;
    end else if (v < (MW+1)'(signed'(-24'sh800000))) begin
      r = -24'sh800000;
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  assign pos_int  = pos_q[PW-1:FW];
  assign wq       = (PW+1)'(win_i) << FW;
  assign p2_sum   = (PW+1)'(pos_q) + ((PW+1)'(win_i) << (FW - 1));
  assign p2_wrap  = (p2_sum >= wq) ? p2_sum - wq : p2_sum;
  assign pos_sum  = (PW+1)'(pos_q) + (PW+1)'(ratio_i);
  assign pos_next = (pos_sum >= wq) ? pos_sum - wq : pos_sum;
  assign div_start = (state_q == dlps_pkg::BK_WRITE);
  assign out_free  = !out_valid_q || out_ready_i;
  assign mac_go    = !((step_q == XF_STEP) && !div_done);

  dlps_div #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .pos_i   (pos_q),
    .win_i   (win_i),
    .done_o  (div_done),
    .cf_o    (cf)
  );

  // operand select per step: four taps, crossfade pair, mix pair
  always_comb begin
    case (step_q)
      3'd0, 3'd1, 3'd2, 3'd3: begin
        x_l = rdata_q[DW-1:SW];
        x_r = rdata_q[SW-1:0];
      end
      3'd4: begin
        x_l = t1_l_q;
        x_r = t1_r_q;
      end
      3'd5: begin
        x_l = t2_l_q;
        x_r = t2_r_q;
      end
      3'd6: begin
        x_l = head_i.item.left_sample;
        x_r = head_i.item.right_sample;
      end
      default: begin
        x_l = wet_l_q;
        x_r = wet_r_q;
      end
    endcase
    case (step_q)
      3'd0:    y_c = dlps_pkg::ONE_Q16 - CW'(f1_q);
      3'd1:    y_c = CW'(f1_q);
      3'd2:    y_c = dlps_pkg::ONE_Q16 - CW'(f2_q);
      3'd3:    y_c = CW'(f2_q);
      3'd4:    y_c = dlps_pkg::ONE_Q16 - cf;
      3'd5:    y_c = cf;
      3'd6:    y_c = dlps_pkg::MIX_ONE - CW'(mix_i);
      default: y_c = CW'(mix_i);
    endcase
  end

  assign sum_l = (MW+1)'(acc_l_q) + (MW+1)'(prod_l_q);
  assign sum_r = (MW+1)'(acc_r_q) + (MW+1)'(prod_r_q);
  assign r16_l = (sum_l + (MW+1)'(32768)) >>> 16;
  assign r16_r = (sum_r + (MW+1)'(32768)) >>> 16;
  assign r15_l = (sum_l + (MW+1)'(16384)) >>> 15;
  assign r15_r = (sum_r + (MW+1)'(16384)) >>> 15;

  // memory port muxing
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = widx_q[AW-1:0];
    mem_wdata = {head_i.item.left_sample, head_i.item.right_sample};
    if (state_q == dlps_pkg::BK_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == dlps_pkg::BK_WRITE) begin
      mem_we = 1'b1;
    end
    case (step_q)
      3'd0:    mem_raddr = next_idx(p1i_q, win_i);
      3'd1:    mem_raddr = p2i_q;
      3'd2:    mem_raddr = next_idx(p2i_q, win_i);
      default: mem_raddr = p1i_q;
    endcase
    if (state_q != dlps_pkg::BK_MAC) begin
      mem_raddr = p1i_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= store_mem[mem_raddr];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      dlps_pkg::BK_CLEAR: begin
        if (clr_q == AW'(DELAY_DEPTH - 1)) state_d = dlps_pkg::BK_IDLE;
      end
      dlps_pkg::BK_IDLE: begin
        if (head_i.valid) state_d = dlps_pkg::BK_NORM;
      end
      dlps_pkg::BK_NORM: begin
        if (WW'(pos_int) < win_i) state_d = dlps_pkg::BK_WRITE;
      end
      dlps_pkg::BK_WRITE: state_d = dlps_pkg::BK_ISSUE;
      dlps_pkg::BK_ISSUE: state_d = dlps_pkg::BK_MAC;
      dlps_pkg::BK_MAC: begin
        if (mac_go && step_q == LAST_STEP) state_d = dlps_pkg::BK_FIN;
      end
      dlps_pkg::BK_FIN: begin
        if (out_free) begin
          pop_o   = 1'b1;
          state_d = dlps_pkg::BK_WRAP;
        end
      end
      dlps_pkg::BK_WRAP: begin
        if (widx_q < win_i) state_d = dlps_pkg::BK_IDLE;
      end
      default: state_d = dlps_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlps_pkg::BK_CLEAR;
      clr_q       <= '0;
      pos_q       <= '0;
      widx_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == dlps_pkg::BK_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == dlps_pkg::BK_NORM && WW'(pos_int) >= win_i) begin
        pos_q[PW-1:FW] <= AW'(WW'(pos_int) - win_i);
      end
      if (state_q == dlps_pkg::BK_ISSUE) step_q <= '0;
      if (state_q == dlps_pkg::BK_MAC && mac_go) step_q <= step_q + 1'b1;
      if (state_q == dlps_pkg::BK_FIN && out_free) begin
        pos_q  <= pos_next[PW-1:0];
        widx_q <= widx_q + 1'b1;
      end
      if (state_q == dlps_pkg::BK_WRAP && widx_q >= win_i) begin
        widx_q <= widx_q - win_i;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == dlps_pkg::BK_WRITE) begin
      p1i_q <= pos_int;
      f1_q  <= pos_q[FW-1:0];
      p2i_q <= p2_wrap[PW-1:FW];
      f2_q  <= p2_wrap[FW-1:0];
    end
    if (state_q == dlps_pkg::BK_MAC && mac_go) begin
      prod_l_q <= MW'(x_l * $signed({1'b0, y_c}));
      prod_r_q <= MW'(x_r * $signed({1'b0, y_c}));
      if (step_q[0]) begin
        acc_l_q <= prod_l_q;
        acc_r_q <= prod_r_q;
      end
      case (step_q)
        3'd2: begin
          t1_l_q <= r16_l[SW-1:0];
          t1_r_q <= r16_r[SW-1:0];
        end
        3'd4: begin
          t2_l_q <= r16_l[SW-1:0];
          t2_r_q <= r16_r[SW-1:0];
        end
        3'd6: begin
          wet_l_q <= r16_l[SW-1:0];
          wet_r_q <= r16_r[SW-1:0];
        end
        default: ;
      endcase
    end
    if (pop_o) begin
      out_q.left_result  <= sat24(r15_l);
      out_q.right_result <= sat24(r15_r);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;
  assign status_o.init_done = (state_q != dlps_pkg::BK_CLEAR);
  assign status_o.busy      = (state_q != dlps_pkg::BK_CLEAR)
                           && (state_q != dlps_pkg::BK_IDLE);

endmodule
`default_nettype wire

@@ design/delay_line_pitch_shifter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// delay_line_pitch_shifter
// Stereo two-tap crossfading delay line pitch shifter.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries one left/right sample pair and
// yields exactly one mixed output pair, in order. Samples are written into a
// DELAY_DEPTH-entry delay store (one 48-bit word per pair); two read taps half
// a window apart are linearly interpolated, crossfaded with a triangle weight
// and mixed with the dry input. In the back end, the four tap reads of a sample
// pair share the store's single read port, the products run through one
// multiplier per channel in eight steps, and the crossfade weight comes from a
// divider that overlaps the reads. After the window shrinks, the first sample
// pair waits while its read position or write index is wrapped back, one window
// length at a time. A two-entry queue in front lets new pairs arrive while one
// is in work, and a result register holds the output while the next pair
// proceeds. After reset the store is cleared, one entry a cycle; in_ready_o
// stays low until that ends. The user must write the registers through
// cfg_we_i/cfg_index_i/cfg_data_i only while the block is idle; the block does
// not enforce this. The pitch ratio follows a write through the registers of
// dlps_ratio.
// ----------------------------------------------------------------------------
module delay_line_pitch_shifter #(
  parameter int unsigned DELAY_DEPTH = dlps_pkg::DELAY_DEPTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // sample input
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire dlps_pkg::in_t                       in_data_i,
  // result output
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output dlps_pkg::out_t                           out_data_o,
  // register writes
  input  wire logic                                cfg_we_i,
  input  wire logic [dlps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [dlps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned WW = $clog2(DELAY_DEPTH + 1);

  // register file
  logic [4:0]  semis_q;
  logic [7:0]  cents_q;
  logic [15:0] mix_q;
  logic [16:0] qual_q;

  logic [15:0] mix_eff;
  logic [16:0] qual_eff;
  logic [29:0] span_mul;
  logic [15:0] win_raw, win_cl;
  logic [WW-1:0] win;
  logic [dlps_pkg::RATIO_W-1:0] ratio;

  dlps_pkg::head_t      head;
  dlps_pkg::bk_status_t bk_status;
  logic                 pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      semis_q <= '0;
      cents_q <= '0;
      mix_q   <= 16'd16384;
      qual_q  <= 17'd32768;
    end else if (cfg_we_i) begin
      case (dlps_pkg::cfg_idx_e'(cfg_index_i))
        dlps_pkg::CFG_SEMITONES: semis_q <= cfg_data_i[4:0];
        dlps_pkg::CFG_CENTS:     cents_q <= cfg_data_i[7:0];
        dlps_pkg::CFG_MIX:       mix_q   <= cfg_data_i[15:0];
        dlps_pkg::CFG_QUALITY:   qual_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // out-of-range register values are clamped on use
  assign mix_eff  = (mix_q > dlps_pkg::MIX_MAX) ? dlps_pkg::MIX_MAX : mix_q;
  assign qual_eff = (qual_q > dlps_pkg::QUAL_MAX) ? dlps_pkg::QUAL_MAX : qual_q;

  // window W = 512 + floor(3584*q / 2^16), then held to 64..DELAY_DEPTH
  assign span_mul = 30'(qual_eff) * 30'(dlps_pkg::WIN_SPAN);
  assign win_raw  = 16'(dlps_pkg::WIN_MIN_BASE) + 16'(span_mul >> 16);
  always_comb begin
    if (win_raw > 16'(DELAY_DEPTH)) begin
      win_cl = 16'(DELAY_DEPTH);
    end else if (win_raw < 16'(dlps_pkg::WIN_FLOOR)) begin
      win_cl = 16'(dlps_pkg::WIN_FLOOR);
    end else begin
      win_cl = win_raw;
    end
  end
  assign win = win_cl[WW-1:0];

  dlps_ratio u_ratio (
    .clk_i   (clk_i),
    .semis_i (semis_q),
    .cents_i (cents_q),
    .ratio_o (ratio)
  );

  // front: accepts pairs into the queue once the store is cleared
  dlps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (bk_status.init_done),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // back: store write, tap reads, crossfade, mix, output register
  dlps_back #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .win_i       (win),
    .ratio_i     (ratio),
    .mix_i       (mix_eff),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .status_o    (bk_status)
  );

  // no transfer may land while the store is still being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> bk_status.init_done)
    else $error("input transfer during store clear");

  // no result before the clear pass is over
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bk_status.init_done)
    else $error("result during store clear");

  // the back end only retires a pair it holds and is working on
  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (head.valid && bk_status.busy))
    else $error("queue pop without an item in work");

  // window always inside the store
  a_window_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win >= WW'(dlps_pkg::WIN_FLOOR)) && (win <= WW'(DELAY_DEPTH)))
    else $error("window out of range");

endmodule
`default_nettype wire
